// File: hdl/cwl_pkg.sv
// ----------------------------------------------------------------------------
// Caption word-wrap layout package
// Shared widths, register indexes, command codes, reset values and types.
// ----------------------------------------------------------------------------
package cwl_pkg;

  localparam int WordLenW  = 5;
  localparam int CoordW    = 16;
  localparam int RowW      = 9;
  localparam int ColW      = 10;
  localparam int GlyphW    = 6;
  localparam int CmdW      = 2;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 10;

  localparam int WordLimit  = 32;
  localparam int QueueDepth = 4;

  localparam int MaxLenInt = (WordLimit - 1 < (1 << WordLenW) - 1) ?
                             WordLimit - 1 : (1 << WordLenW) - 1;
  localparam logic [WordLenW-1:0] MaxWordLen = WordLenW'(MaxLenInt);

  localparam logic [9:0] AreaLeftRst   = 10'd0;
  localparam logic [8:0] AreaTopRst    = 9'd0;
  localparam logic [9:0] AreaRightRst  = 10'd800;
  localparam logic [8:0] AreaBottomRst = 9'd480;
  localparam logic [5:0] GlyphWidthRst = 6'd17;
  localparam logic [5:0] GlyphHeightRst = 6'd24;
  localparam logic [8:0] GridRowsRst   = 9'd20;
  localparam logic [9:0] GridColsRst   = 10'd47;

  typedef enum logic [CmdW-1:0] {
    CMD_DRAW    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_REFRESH = 2'd2
  } cwl_cmd_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_AREA_LEFT    = 3'd0,
    REG_AREA_TOP     = 3'd1,
    REG_AREA_RIGHT   = 3'd2,
    REG_AREA_BOTTOM  = 3'd3,
    REG_GLYPH_WIDTH  = 3'd4,
    REG_GLYPH_HEIGHT = 3'd5,
    REG_GRID_ROWS    = 3'd6,
    REG_GRID_COLS    = 3'd7
  } cwl_reg_t;

  typedef struct packed {
    logic [9:0]        area_left;
    logic [8:0]        area_top;
    logic [9:0]        area_right;
    logic [8:0]        area_bottom;
    logic [GlyphW-1:0] glyph_width;
    logic [GlyphW-1:0] glyph_height;
    logic [RowW-1:0]   grid_rows;
    logic [ColW-1:0]   grid_cols;
  } cwl_cfg_t;

  typedef struct packed {
    logic                flush;
    logic [WordLenW-1:0] len;
  } cwl_item_t;

endpackage

// File: hdl/cwl_if.sv
// ----------------------------------------------------------------------------
// Caption layout channels
// Valid/ready channels for word items and for drawing results.
// ----------------------------------------------------------------------------
interface cwl_in_if import cwl_pkg::*;;
  logic                valid;
  logic                ready;
  logic                action;
  logic [WordLenW-1:0] word_length;

  modport source(output valid, action, word_length, input ready);
  modport sink(input valid, action, word_length, output ready);
endinterface

interface cwl_out_if import cwl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [CoordW-1:0] left_x;
  logic [CoordW-1:0] top_y;
  logic [CoordW-1:0] right_x;
  logic [CoordW-1:0] bottom_y;
  logic              last_of_run;

  modport source(output valid, command, left_x, top_y, right_x, bottom_y, last_of_run,
                 input ready);
  modport sink(input valid, command, left_x, top_y, right_x, bottom_y, last_of_run,
               output ready);
endinterface

// File: hdl/cwl_cfg_regs.sv
// ----------------------------------------------------------------------------
// Caption layout configuration registers
// Decodes indexed writes into the window, glyph and grid registers.
// ----------------------------------------------------------------------------
module cwl_cfg_regs import cwl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [CfgDataW-1:0]  wr_data,
  output cwl_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.area_left    <= AreaLeftRst;
      cfg.area_top     <= AreaTopRst;
      cfg.area_right   <= AreaRightRst;
      cfg.area_bottom  <= AreaBottomRst;
      cfg.glyph_width  <= GlyphWidthRst;
      cfg.glyph_height <= GlyphHeightRst;
      cfg.grid_rows    <= GridRowsRst;
      cfg.grid_cols    <= GridColsRst;
    end else if (wr_en) begin
      case (cwl_reg_t'(wr_index))
        REG_AREA_LEFT:    cfg.area_left    <= wr_data[9:0];
        REG_AREA_TOP:     cfg.area_top     <= wr_data[8:0];
        REG_AREA_RIGHT:   cfg.area_right   <= wr_data[9:0];
        REG_AREA_BOTTOM:  cfg.area_bottom  <= wr_data[8:0];
        REG_GLYPH_WIDTH:  cfg.glyph_width  <= wr_data[GlyphW-1:0];
        REG_GLYPH_HEIGHT: cfg.glyph_height <= wr_data[GlyphW-1:0];
        REG_GRID_ROWS:    cfg.grid_rows    <= wr_data[RowW-1:0];
        REG_GRID_COLS:    cfg.grid_cols    <= wr_data[ColW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/cwl_front.sv
// ----------------------------------------------------------------------------
// Caption layout front end
// Accepts word and flush beats, limits word length and queues the items.
// ----------------------------------------------------------------------------
module cwl_front import cwl_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  cwl_in_if.sink     item,
  output logic       q_valid,
  output cwl_item_t  q_item,
  input  logic       q_ready
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cwl_item_t       mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  cwl_item_t       entry;
  logic            push;
  logic            pop;

  assign item.ready = (count != CntW'(DEPTH));
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != '0);
  assign pop        = q_valid && q_ready;
  assign q_item     = mem[rd_ptr];

  always_comb begin
    entry.flush = item.action;
    entry.len   = (item.word_length > MaxWordLen) ? MaxWordLen : item.word_length;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/cwl_rem.sv
// ----------------------------------------------------------------------------
// Caption layout row remainder unit
// Restoring remainder, one dividend bit per cycle, for the row wrap.
// ----------------------------------------------------------------------------
module cwl_rem import cwl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [RowW:0]   dividend,
  input  logic [RowW-1:0] divisor,
  output logic            done,
  output logic [RowW-1:0] rem
);

  localparam int StepW = $clog2(RowW + 2);

  logic             busy;
  logic [StepW-1:0] steps;
  logic [RowW:0]    bits;
  logic [RowW:0]    trial;
  logic [RowW-1:0]  rem_next;

  always_comb begin
    trial    = {rem, bits[RowW]};
    rem_next = (trial >= {1'b0, divisor}) ? RowW'(trial - {1'b0, divisor}) : trial[RowW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (steps == StepW'(1));
      if (start) begin
        busy  <= 1'b1;
        bits  <= dividend;
        rem   <= '0;
        steps <= StepW'(RowW + 1);
      end else if (busy) begin
        rem   <= rem_next;
        bits  <= {bits[RowW-1:0], 1'b0};
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hdl/cwl_back.sv
// ----------------------------------------------------------------------------
// Caption layout back end
// Holds the cursor and dirty box, computes rectangles, emits result beats.
// ----------------------------------------------------------------------------
module cwl_back import cwl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cwl_cfg_t   cfg,
  input  logic       q_valid,
  input  cwl_item_t  q_item,
  output logic       q_ready,
  cwl_out_if.source  result
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_MUL, S_DRAW, S_CLEAR, S_REFRESH, S_FLUSH
  } state_t;

  state_t              state;
  logic [RowW-1:0]     cursor_row;
  logic [ColW-1:0]     cursor_col;
  logic [WordLenW-1:0] len;
  logic                wrapped;
  logic                clear_due;
  logic                pending_update;
  logic [CoordW-1:0]   dirty_min_x;
  logic [CoordW-1:0]   dirty_max_x;
  logic [CoordW-1:0]   dirty_min_y;
  logic [CoordW-1:0]   dirty_max_y;
  logic [CoordW-1:0]   p_col;
  logic [CoordW-1:0]   p_row;
  logic [CoordW-1:0]   p_len;
  logic [CoordW-1:0]   p_cs;
  logic [CoordW-1:0]   p_ce;
  logic                res_valid;
  cwl_cmd_t            res_cmd;
  logic [CoordW-1:0]   res_l;
  logic [CoordW-1:0]   res_t;
  logic [CoordW-1:0]   res_r;
  logic [CoordW-1:0]   res_b;
  logic                res_last;

  logic [ColW:0]       col_sum;
  logic                wrap_hit;
  logic [RowW:0]       row_inc;
  logic [RowW:0]       rows_ext;
  logic [RowW:0]       rows_dbl;
  logic [RowW-1:0]     half;
  logic                hit_mid;
  logic                hit_last;
  logic [RowW-1:0]     clr_start;
  logic [RowW-1:0]     clr_end;
  logic                out_free;
  logic                res_load;
  logic                rem_start;
  logic                rem_done;
  logic [RowW-1:0]     rem_val;
  logic [CoordW-1:0]   sx;
  logic [CoordW-1:0]   sy;
  logic [CoordW-1:0]   ex;
  logic [CoordW-1:0]   ey;

  always_comb begin
    col_sum   = {1'b0, cursor_col} + (ColW + 1)'(q_item.len);
    wrap_hit  = (col_sum >= {1'b0, cfg.grid_cols});
    row_inc   = {1'b0, cursor_row} + 1'b1;
    rows_ext  = {1'b0, cfg.grid_rows};
    rows_dbl  = {cfg.grid_rows, 1'b0};
    half      = cfg.grid_rows >> 1;
    hit_mid   = wrapped && (half != '0) && (cursor_row == half - 1'b1);
    hit_last  = wrapped && (cfg.grid_rows != '0) && (cursor_row == cfg.grid_rows - 1'b1);
    clr_start = hit_mid ? half : '0;
    clr_end   = hit_mid ? cfg.grid_rows : half;
    out_free  = !res_valid || result.ready;
    res_load  = out_free && ((state inside {S_DRAW, S_CLEAR, S_REFRESH}) ||
                             (state == S_FLUSH && pending_update));
    q_ready   = (state == S_IDLE);
    rem_start = (state == S_IDLE) && q_valid && !q_item.flush && wrap_hit &&
                (cfg.grid_rows != '0) && (row_inc >= rows_dbl);
    sx = CoordW'(cfg.area_left) + p_col;
    sy = CoordW'(cfg.area_top) + p_row;
    ex = sx + p_len;
    ey = sy + CoordW'(cfg.glyph_height);
  end

  cwl_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (row_inc),
    .divisor  (cfg.grid_rows),
    .done     (rem_done),
    .rem      (rem_val)
  );

  assign result.valid       = res_valid;
  assign result.command     = res_cmd;
  assign result.left_x      = res_l;
  assign result.top_y       = res_t;
  assign result.right_x     = res_r;
  assign result.bottom_y    = res_b;
  assign result.last_of_run = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cursor_row     <= '0;
      cursor_col     <= '0;
      pending_update <= 1'b0;
      dirty_min_x    <= CoordW'(AreaRightRst);
      dirty_max_x    <= CoordW'(AreaLeftRst);
      dirty_min_y    <= CoordW'(AreaBottomRst);
      dirty_max_y    <= CoordW'(AreaTopRst);
      res_valid      <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            len <= q_item.len;
            if (q_item.flush) begin
              state <= S_FLUSH;
            end else begin
              wrapped <= wrap_hit;
              state   <= rem_start ? S_MOD : S_MUL;
              if (wrap_hit) begin
                cursor_col <= '0;
                if (cfg.grid_rows == '0) begin
                  cursor_row <= '0;
                end else if (row_inc < rows_ext) begin
                  cursor_row <= row_inc[RowW-1:0];
                end else if (row_inc < rows_dbl) begin
                  cursor_row <= RowW'(row_inc - rows_ext);
                end
              end
            end
          end
        end
        S_MOD: begin
          if (rem_done) begin
            cursor_row <= rem_val;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          p_col     <= CoordW'(cursor_col) * CoordW'(cfg.glyph_width);
          p_row     <= CoordW'(cursor_row) * CoordW'(cfg.glyph_height);
          p_len     <= CoordW'(len) * CoordW'(cfg.glyph_width);
          p_cs      <= CoordW'(clr_start) * CoordW'(cfg.glyph_height);
          p_ce      <= CoordW'(clr_end) * CoordW'(cfg.glyph_height);
          clear_due <= hit_mid || hit_last;
          state     <= S_DRAW;
        end
        S_DRAW: begin
          if (out_free) begin
            res_cmd   <= CMD_DRAW;
            res_l     <= sx;
            res_t     <= sy;
            res_r     <= ex;
            res_b     <= ey;
            res_last  <= !clear_due;
            if (sx < dirty_min_x) dirty_min_x <= sx;
            if (sy < dirty_min_y) dirty_min_y <= sy;
            if (ex > dirty_max_x) dirty_max_x <= ex;
            if (ey > dirty_max_y) dirty_max_y <= ey;
            pending_update <= 1'b1;
            cursor_col     <= cursor_col + ColW'(len) + 1'b1;
            state          <= clear_due ? S_CLEAR : S_IDLE;
          end
        end
        S_CLEAR: begin
          if (out_free) begin
            res_cmd   <= CMD_CLEAR;
            res_l     <= CoordW'(cfg.area_left);
            res_t     <= CoordW'(cfg.area_top) + p_cs;
            res_r     <= CoordW'(cfg.area_right);
            res_b     <= CoordW'(cfg.area_top) + p_ce;
            res_last  <= 1'b0;
            state     <= S_REFRESH;
          end
        end
        S_REFRESH: begin
          if (out_free) begin
            res_cmd        <= CMD_REFRESH;
            res_l          <= CoordW'(cfg.area_left);
            res_t          <= CoordW'(cfg.area_top);
            res_r          <= CoordW'(cfg.area_right);
            res_b          <= CoordW'(cfg.area_bottom);
            res_last       <= 1'b1;
            dirty_min_x    <= CoordW'(cfg.area_right);
            dirty_max_x    <= CoordW'(cfg.area_left);
            dirty_min_y    <= CoordW'(cfg.area_bottom);
            dirty_max_y    <= CoordW'(cfg.area_top);
            pending_update <= 1'b0;
            state          <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!pending_update || out_free) begin
            if (pending_update) begin
              res_cmd   <= CMD_REFRESH;
              res_l     <= dirty_min_x;
              res_t     <= dirty_min_y;
              res_r     <= dirty_max_x;
              res_b     <= dirty_max_y;
              res_last  <= 1'b1;
            end
            dirty_min_x    <= CoordW'(cfg.area_right);
            dirty_max_x    <= CoordW'(cfg.area_left);
            dirty_min_y    <= CoordW'(cfg.area_bottom);
            dirty_max_y    <= CoordW'(cfg.area_top);
            pending_update <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/caption_word_wrap_layout_core.sv
// ----------------------------------------------------------------------------
// Caption word-wrap layout core
// Places caption words on a character grid and emits draw, clear and
// refresh rectangles.
//
// The item channel carries one beat per word or flush. Words go into a small
// queue, so the source is held off only when the queue is full. The result
// channel carries zero to three beats per item; last_of_run marks the final one.
// A word that does not wrap passes the layout sequencer in order: fetch
// and wrap test, the glyph multiplies, then the draw beat. A wrap that enters
// a clearing row adds a clear and a refresh beat. A flush passes the fetch
// and a flush step. If the row count was lowered so far that the next row
// reaches twice the row count, the wrap runs through the bit-serial remainder
// unit. An item beat taken by an idle sequencer is queued, fetched and
// multiplied before its draw beat is registered.
// The result register holds its beat while ready is low, and the sequencer
// waits; the item queue keeps accepting until it is full.
// Reset empties the queue, homes the cursor, loads the registers with their
// defaults and sets the dirty box from them. The user must write registers only
// while the core is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module caption_word_wrap_layout_core import cwl_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [CfgDataW-1:0]  wr_data,
  cwl_in_if.sink               item,
  cwl_out_if.source            result
);

  cwl_cfg_t  cfg;
  logic      q_valid;
  logic      q_ready;
  cwl_item_t q_item;

  cwl_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  cwl_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  cwl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .result  (result)
  );

endmodule

// File: hdl/cwl_checker.sv
// ----------------------------------------------------------------------------
// Caption layout port checker
// Checks the ordering and marking of result beats seen at the top level.
// ----------------------------------------------------------------------------
module cwl_checker import cwl_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            valid,
  input logic            ready,
  input logic [CmdW-1:0] command,
  input logic            last_of_run
);

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("Result beat shown right after reset.");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("Result beat dropped while stalled.");

  a_refresh_ends_run: assert property (@(posedge clk) disable iff (rst)
    valid && command == CMD_REFRESH |-> last_of_run)
    else $error("Refresh beat not marked as the last of its run.");

  a_clear_not_last: assert property (@(posedge clk) disable iff (rst)
    valid && command == CMD_CLEAR |-> !last_of_run)
    else $error("Clear beat marked as the last of its run.");

  a_clear_then_refresh: assert property (@(posedge clk) disable iff (rst)
    valid && ready && command == CMD_CLEAR |=> !valid || command == CMD_REFRESH)
    else $error("Clear beat not followed by a refresh beat.");

endmodule

bind caption_word_wrap_layout_core cwl_checker u_cwl_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .command     (result.command),
  .last_of_run (result.last_of_run)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Caption word-wrap layout testbench
// Sends word and flush items to the layout core, predicts every draw, clear
// and refresh rectangle from its own copy of the cursor, dirty box and
// registers, and compares each result beat field by field. Directed tests
// cover the default grid, clearing rows, tiny and shrunk grids and register
// extremes; random phases then reprogram the window and stall both channels.
// ----------------------------------------------------------------------------
module testbench;
  import cwl_pkg::*;

  localparam int SettleCycles = 64;

  typedef struct {
    cwl_cmd_t    cmd;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic        last;
  } rect_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CfgIndexW-1:0] wr_index;
  logic [CfgDataW-1:0]  wr_data;

  cwl_in_if  item_ch ();
  cwl_out_if result_ch ();

  caption_word_wrap_layout_core dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  cwl_cfg_t    cfg_now;
  logic [8:0]  row_now;
  logic [9:0]  col_now;
  logic [15:0] box_x0;
  logic [15:0] box_x1;
  logic [15:0] box_y0;
  logic [15:0] box_y1;
  bit          box_dirty;

  rect_t       awaited_rects[$];
  int unsigned mismatches = 0;
  bit          src_eager = 1'b0;
  bit          sink_eager = 1'b0;
  int unsigned stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rect_t make_rect(cwl_cmd_t cmd, logic [15:0] x0, logic [15:0] y0,
                                      logic [15:0] x1, logic [15:0] y1);
    rect_t r;
    r.cmd  = cmd;
    r.x0   = x0;
    r.y0   = y0;
    r.x1   = x1;
    r.y1   = y1;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic reset_box();
    box_x0    = 16'(cfg_now.area_right);
    box_x1    = 16'(cfg_now.area_left);
    box_y0    = 16'(cfg_now.area_bottom);
    box_y1    = 16'(cfg_now.area_top);
    box_dirty = 1'b0;
  endtask

  task automatic model_reset();
    cfg_now = {AreaLeftRst, AreaTopRst, AreaRightRst, AreaBottomRst,
               GlyphWidthRst, GlyphHeightRst, GridRowsRst, GridColsRst};
    row_now = '0;
    col_now = '0;
    reset_box();
  endtask

  // Works out the beats that one accepted item causes and queues them.
  task automatic model_item(logic flush, logic [WordLenW-1:0] len_in);
    rect_t       run[$];
    int unsigned al, at, gw, gh, rows, half, len, col, row, sx, sy, ex, ey, rs, re;
    bit          clr;
    al   = 32'(cfg_now.area_left);
    at   = 32'(cfg_now.area_top);
    gw   = 32'(cfg_now.glyph_width);
    gh   = 32'(cfg_now.glyph_height);
    rows = 32'(cfg_now.grid_rows);
    half = rows / 2;
    clr  = 1'b0;
    rs   = 0;
    re   = 0;
    if (flush) begin
      if (box_dirty) run.push_back(make_rect(CMD_REFRESH, box_x0, box_y0, box_x1, box_y1));
      reset_box();
    end else begin
      len = 32'(len_in);
      if (len > 32'(MaxWordLen)) len = 32'(MaxWordLen);
      col = 32'(col_now);
      row = 32'(row_now);
      if (col + len >= 32'(cfg_now.grid_cols)) begin
        col = 0;
        row = (rows == 0) ? 0 : (row + 1) % rows;
        if (half >= 1 && row == half - 1) begin
          clr = 1'b1;
          rs  = half;
          re  = rows;
        end else if (rows >= 1 && row == rows - 1) begin
          clr = 1'b1;
          rs  = 0;
          re  = half;
        end
      end
      sx = (al + col * gw) & 32'hFFFF;
      sy = (at + row * gh) & 32'hFFFF;
      ex = (sx + len * gw) & 32'hFFFF;
      ey = (sy + gh) & 32'hFFFF;
      if (16'(sx) < box_x0) box_x0 = 16'(sx);
      if (16'(sy) < box_y0) box_y0 = 16'(sy);
      if (16'(ex) > box_x1) box_x1 = 16'(ex);
      if (16'(ey) > box_y1) box_y1 = 16'(ey);
      box_dirty = 1'b1;
      run.push_back(make_rect(CMD_DRAW, 16'(sx), 16'(sy), 16'(ex), 16'(ey)));
      row_now = 9'(row);
      col_now = 10'(col + len + 1);
      if (clr) begin
        run.push_back(make_rect(CMD_CLEAR, 16'(al), 16'(at + rs * gh),
                                16'(cfg_now.area_right), 16'(at + re * gh)));
        run.push_back(make_rect(CMD_REFRESH, 16'(al), 16'(at), 16'(cfg_now.area_right),
                                16'(cfg_now.area_bottom)));
        reset_box();
      end
    end
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) awaited_rects.push_back(run[i]);
  endtask

  // Leaves wr_en high so that back-to-back writes run without a gap.
  task automatic write_reg(cwl_reg_t idx, logic [CfgDataW-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_AREA_LEFT:    cfg_now.area_left    = data;
      REG_AREA_TOP:     cfg_now.area_top     = data[8:0];
      REG_AREA_RIGHT:   cfg_now.area_right   = data;
      REG_AREA_BOTTOM:  cfg_now.area_bottom  = data[8:0];
      REG_GLYPH_WIDTH:  cfg_now.glyph_width  = data[5:0];
      REG_GLYPH_HEIGHT: cfg_now.glyph_height = data[5:0];
      REG_GRID_ROWS:    cfg_now.grid_rows    = data[8:0];
      REG_GRID_COLS:    cfg_now.grid_cols    = data;
      default: ;
    endcase
  endtask

  task automatic load_config(cwl_cfg_t c);
    write_reg(REG_AREA_LEFT, 10'(c.area_left));
    write_reg(REG_AREA_TOP, 10'(c.area_top));
    write_reg(REG_AREA_RIGHT, 10'(c.area_right));
    write_reg(REG_AREA_BOTTOM, 10'(c.area_bottom));
    write_reg(REG_GLYPH_WIDTH, 10'(c.glyph_width));
    write_reg(REG_GLYPH_HEIGHT, 10'(c.glyph_height));
    write_reg(REG_GRID_ROWS, 10'(c.grid_rows));
    write_reg(REG_GRID_COLS, 10'(c.grid_cols));
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(logic flush, logic [WordLenW-1:0] len);
    int unsigned gap;
    gap = src_eager ? 0 : pick_gap();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= flush;
    item_ch.word_length <= len;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    model_item(flush, len);
  endtask

  // A flush that causes no beat may still be in the core when the last
  // awaited beat arrives, so the core is given time to settle.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_rects.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    rect_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (awaited_rects.size() == 0) begin
        $display("%0t: unexpected beat, command expected none, actual %0d",
                 $time, result_ch.command);
        mismatches++;
      end else begin
        want = awaited_rects.pop_front();
        check_field("command", 16'(want.cmd), 16'(result_ch.command));
        check_field("left_x", want.x0, result_ch.left_x);
        check_field("top_y", want.y0, result_ch.top_y);
        check_field("right_x", want.x1, result_ch.right_x);
        check_field("bottom_y", want.y1, result_ch.bottom_y);
        check_field("last_of_run", 16'(want.last), 16'(result_ch.last_of_run));
      end
    end
  end

  always @(posedge clk) begin : drive_result_ready
    if (sink_eager || rst) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  task automatic test_default_grid();
    send_item(1'b0, 5'd0);
    send_item(1'b0, 5'd31);
    send_item(1'b0, 5'd5);
    send_item(1'b1, 5'd0);
    send_item(1'b1, 5'd31);
    send_item(1'b0, 5'd31);
    drain_results();
  endtask

  task automatic test_clearing_rows();
    load_config({10'd3, 9'd2, 10'd200, 9'd100, 6'd5, 6'd7, 9'd4, 10'd8});
    repeat (5) send_item(1'b0, 5'd7);
    send_item(1'b1, 5'd0);
    drain_results();
  endtask

  task automatic test_tiny_grids();
    load_config({10'd10, 9'd20, 10'd300, 9'd200, 6'd4, 6'd6, 9'd1, 10'd8});
    repeat (2) send_item(1'b0, 5'd8);
    drain_results();
    load_config({10'd10, 9'd20, 10'd300, 9'd200, 6'd4, 6'd6, 9'd0, 10'd8});
    repeat (2) send_item(1'b0, 5'd9);
    drain_results();
    load_config({10'd10, 9'd20, 10'd300, 9'd200, 6'd4, 6'd6, 9'd2, 10'd8});
    repeat (2) send_item(1'b0, 5'd8);
    drain_results();
  endtask

  task automatic test_register_extremes();
    load_config({10'd1023, 9'd511, 10'd1023, 9'd511, 6'd63, 6'd63, 9'd511, 10'd1023});
    send_item(1'b0, 5'd31);
    send_item(1'b0, 5'd31);
    send_item(1'b1, 5'd0);
    drain_results();
    load_config('0);
    send_item(1'b0, 5'd0);
    send_item(1'b0, 5'd31);
    drain_results();
  endtask

  // The cursor is left beyond a grid that is then made smaller.
  task automatic test_shrunk_grid();
    load_config({10'd0, 9'd0, 10'd800, 9'd480, 6'd17, 6'd24, 9'd40, 10'd8});
    repeat (3) send_item(1'b0, 5'd12);
    drain_results();
    load_config({10'd0, 9'd0, 10'd800, 9'd480, 6'd17, 6'd24, 9'd2, 10'd8});
    send_item(1'b0, 5'd3);
    send_item(1'b1, 5'd0);
    drain_results();
  endtask

  function automatic cwl_cfg_t random_cfg();
    cwl_cfg_t c;
    c.area_left    = 10'($urandom_range(0, 1023));
    c.area_top     = 9'($urandom_range(0, 511));
    c.area_right   = 10'($urandom_range(0, 1023));
    c.area_bottom  = 9'($urandom_range(0, 511));
    c.glyph_width  = 6'($urandom_range(0, 63));
    c.glyph_height = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 7))
      0: c.grid_rows = 9'($urandom_range(0, 1));
      1: c.grid_rows = 9'($urandom_range(2, 511));
      default: c.grid_rows = 9'($urandom_range(2, 8));
    endcase
    if ($urandom_range(0, 7) == 0) c.grid_cols = 10'($urandom_range(0, 1023));
    else c.grid_cols = 10'($urandom_range(8, 48));
    return c;
  endfunction

  task automatic test_random_layouts();
    int unsigned mode;
    for (int phase = 0; phase < 12; phase++) begin
      mode       = phase % 4;
      src_eager  = (mode == 1);
      sink_eager = (mode == 2);
      load_config(random_cfg());
      for (int n = 0; n < 30; n++) begin
        if ($urandom_range(0, 99) < 15) send_item(1'b1, 5'($urandom_range(0, 31)));
        else send_item(1'b0, 5'($urandom_range(0, 31)));
      end
      drain_results();
    end
    src_eager  = 1'b0;
    sink_eager = 1'b0;
  endtask

  initial begin
    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_index            <= REG_AREA_LEFT;
    wr_data             <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.action      <= 1'b0;
    item_ch.word_length <= '0;
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_grid();
    test_clearing_rows();
    test_tiny_grids();
    test_register_extremes();
    test_shrunk_grid();
    test_random_layouts();
    drain_results();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
